[design/mtep_pkg.sv]
// shared types and constants of the midi track event parser
package mtep_pkg;

  localparam int unsigned MAX_VLQ_BYTES_DEF = 4;

  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] STATUS_SYSTEM    = 8'hF0;
  localparam logic [7:0] STATUS_HI_MASK   = 8'hF0;
  localparam logic [7:0] HI_PROGRAM       = 8'hC0;
  localparam logic [7:0] HI_PRESSURE      = 8'hD0;
  localparam logic [7:0] META_TEMPO       = 8'h51;
  localparam logic [27:0] TEMPO_LEN       = 28'd3;
  localparam logic [23:0] TEMPO_MIN_PERIOD = 24'd60061;

  typedef enum logic [2:0] {
    KIND_SHORT     = 3'd0,
    KIND_META      = 3'd1,
    KIND_SYSEX     = 3'd2,
    KIND_PAYLOAD   = 3'd3,
    KIND_TRACK_END = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic [27:0] payload_length;
    logic [23:0] tempo_period;
    logic        tempo_valid;
    logic        payload_last;
    logic        track_done;
    logic        truncated;
  } result_t;

endpackage

[design/mtep_core.sv]
// parser state registers and per-byte next-state and result logic
module mtep_core #(
  parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              track_end_i,
  input  logic              file_start_i,
  output logic              have_o,
  output mtep_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_VLQ_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VLQ_BYTES);

  typedef enum logic [2:0] {
    PH_DELTA    = 3'd0,
    PH_STATUS   = 3'd1,
    PH_DATA1    = 3'd2,
    PH_DATA2    = 3'd3,
    PH_METATYPE = 3'd4,
    PH_LENGTH   = 3'd5,
    PH_PAYLOAD  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [31:0] tick_q, tick_d, tick_c;
  logic [7:0]  run_q, run_d, run_c;
  logic [7:0]  cur_q, cur_d, cur_c;
  logic [31:0] acc_q, acc_d, acc_c;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_c;
  logic [7:0]  meta_q, meta_d, meta_c;
  logic [27:0] length_q, length_d, length_c;
  logic [27:0] left_q, left_d, left_c;
  logic [7:0]  first_q, first_d, first_c;
  logic [23:0] tempo_q, tempo_d, tempo_c;
  logic        found_q, found_d, found_c;

  logic [31:0] vlq_acc;
  logic [CntW-1:0] vlq_cnt;
  logic        vlq_done;
  logic [7:0]  d1_status;
  logic [7:0]  d1_hi;
  logic        d1_one;
  logic [27:0] left_n;
  logic [23:0] tempo_n;
  logic [27:0] vlq_len;
  logic        is_meta;

  // a file start wipes track state and the tempo flag before the byte is parsed
  always_comb begin
    if (file_start_i) begin
      phase_c  = PH_DELTA;
      tick_c   = '0;
      run_c    = '0;
      cur_c    = '0;
      acc_c    = '0;
      cnt_c    = '0;
      meta_c   = '0;
      length_c = '0;
      left_c   = '0;
      first_c  = '0;
      tempo_c  = '0;
      found_c  = 1'b0;
    end else begin
      phase_c  = phase_q;
      tick_c   = tick_q;
      run_c    = run_q;
      cur_c    = cur_q;
      acc_c    = acc_q;
      cnt_c    = cnt_q;
      meta_c   = meta_q;
      length_c = length_q;
      left_c   = left_q;
      first_c  = first_q;
      tempo_c  = tempo_q;
      found_c  = found_q;
    end
  end

  assign vlq_acc  = {acc_c[24:0], data_byte_i[6:0]};
  assign vlq_cnt  = cnt_c + CntW'(1);
  assign vlq_done = !data_byte_i[7] || (vlq_cnt >= CntMax);
  assign vlq_len  = vlq_acc[27:0];
  assign is_meta  = (cur_c == mtep_pkg::STATUS_META);

  // a data byte straight after the delta takes the running status
  assign d1_status = (phase_c == PH_STATUS) ? run_c : cur_c;
  assign d1_hi     = d1_status & mtep_pkg::STATUS_HI_MASK;
  assign d1_one    = (d1_hi == mtep_pkg::HI_PROGRAM) || (d1_hi == mtep_pkg::HI_PRESSURE);

  assign left_n  = left_c - 28'd1;
  assign tempo_n = {tempo_c[15:0], data_byte_i};

  always_comb begin
    phase_d  = phase_c;
    tick_d   = tick_c;
    run_d    = run_c;
    cur_d    = cur_c;
    acc_d    = acc_c;
    cnt_d    = cnt_c;
    meta_d   = meta_c;
    length_d = length_c;
    left_d   = left_c;
    first_d  = first_c;
    tempo_d  = tempo_c;
    found_d  = found_c;
    have_o   = 1'b0;
    res_o    = '0;

    unique case (phase_c)
      PH_DELTA: begin
        acc_d = vlq_acc;
        cnt_d = vlq_cnt;
        if (vlq_done) begin
          tick_d  = tick_c + vlq_acc;
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (phase_c == PH_STATUS && data_byte_i[7]) begin
          cur_d = data_byte_i;
          if (data_byte_i < mtep_pkg::STATUS_SYSTEM) begin
            run_d = data_byte_i;
          end
          if (data_byte_i == mtep_pkg::STATUS_META) begin
            phase_d = PH_METATYPE;
          end else if (data_byte_i == mtep_pkg::STATUS_SYSEX ||
                       data_byte_i == mtep_pkg::STATUS_SYSEX_ESC) begin
            phase_d = PH_LENGTH;
          end else begin
            phase_d = PH_DATA1;
          end
        end else begin
          cur_d   = d1_status;
          first_d = data_byte_i;
          if (d1_one) begin
            have_o            = 1'b1;
            res_o.kind        = mtep_pkg::KIND_SHORT;
            res_o.status      = d1_status;
            res_o.first_value = data_byte_i;
            phase_d           = PH_DELTA;
          end else begin
            phase_d = PH_DATA2;
          end
        end
      end
      PH_DATA2: begin
        have_o             = 1'b1;
        res_o.kind         = mtep_pkg::KIND_SHORT;
        res_o.status       = cur_c;
        res_o.first_value  = first_c;
        res_o.second_value = data_byte_i;
        phase_d            = PH_DELTA;
      end
      PH_METATYPE: begin
        meta_d  = data_byte_i;
        phase_d = PH_LENGTH;
      end
      PH_LENGTH: begin
        acc_d = vlq_acc;
        cnt_d = vlq_cnt;
        if (vlq_done) begin
          length_d             = vlq_len;
          left_d               = vlq_len;
          tempo_d              = '0;
          acc_d                = '0;
          cnt_d                = '0;
          have_o               = 1'b1;
          res_o.kind           = is_meta ? mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
          res_o.status         = cur_c;
          res_o.first_value    = is_meta ? meta_c : 8'h00;
          res_o.payload_length = vlq_len;
          res_o.payload_last   = (vlq_len == '0);
          phase_d              = (vlq_len == '0) ? PH_DELTA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        tempo_d              = tempo_n;
        left_d               = left_n;
        have_o               = 1'b1;
        res_o.kind           = mtep_pkg::KIND_PAYLOAD;
        res_o.status         = cur_c;
        res_o.first_value    = data_byte_i;
        res_o.payload_length = length_c;
        res_o.payload_last   = (left_n == '0);
        if (left_n == '0) begin
          phase_d = PH_DELTA;
          // first tempo of the file, slow enough to be a sensible bpm
          if (is_meta && meta_c == mtep_pkg::META_TEMPO &&
              length_c == mtep_pkg::TEMPO_LEN && !found_c &&
              tempo_n >= mtep_pkg::TEMPO_MIN_PERIOD) begin
            res_o.tempo_period = tempo_n;
            res_o.tempo_valid  = 1'b1;
            found_d            = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_DELTA;
      end
    endcase

    res_o.tick    = tick_d;
    res_o.channel = (res_o.status < mtep_pkg::STATUS_SYSTEM) ? res_o.status[3:0] : 4'h0;

    if (track_end_i) begin
      if (!have_o) begin
        have_o        = 1'b1;
        res_o.kind    = mtep_pkg::KIND_TRACK_END;
        res_o.status  = 8'h00;
        res_o.channel = 4'h0;
      end
      res_o.track_done = 1'b1;
      res_o.truncated  = !(phase_d == PH_DELTA && cnt_d == '0);
      phase_d  = PH_DELTA;
      tick_d   = '0;
      run_d    = '0;
      cur_d    = '0;
      acc_d    = '0;
      cnt_d    = '0;
      meta_d   = '0;
      length_d = '0;
      left_d   = '0;
      first_d  = '0;
      tempo_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      tick_q   <= '0;
      run_q    <= '0;
      cur_q    <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      meta_q   <= '0;
      length_q <= '0;
      left_q   <= '0;
      first_q  <= '0;
      tempo_q  <= '0;
      found_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      run_q    <= run_d;
      cur_q    <= cur_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      meta_q   <= meta_d;
      length_q <= length_d;
      left_q   <= left_d;
      first_q  <= first_d;
      tempo_q  <= tempo_d;
      found_q  <= found_d;
    end
  end

endmodule

[design/mtep_skid.sv]
// result register with a skid stage so the input side keeps flowing under stall
module mtep_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtep_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mtep_pkg::result_t data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  mtep_pkg::result_t out_q;
  mtep_pkg::result_t skid_q;
  logic              out_free;

  assign out_free = !out_valid_q || ready_i;
  assign space_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

[design/midi_track_event_parser.sv]
// top level of the midi track event parser
//
// Takes the body of a midi file track one byte per transfer on the s_axis
// channel: tdata is the byte, tlast marks the final byte of the track and
// tuser marks the first byte of a new file. Each byte updates the parser
// state (delta accumulator, absolute tick, running status, event phase)
// in the cycle it is transferred and yields at most one result.
// Results leave on m_axis: tuser carries the kind (short event, meta or
// sysex header, payload byte, track end), tlast marks the result of the
// track's last byte and tdata carries the remaining fields.
// One byte is taken every cycle while s_axis_tready is high; each result
// is registered in the result register, or in the skid stage on stall.
// When the receiver stalls, a skid stage holds one more result and
// s_axis_tready drops only once both are full.
// Reset clears all parser state, the tempo flag and both result stages.
module midi_track_event_parser #(
  parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // track_end
  input  logic         s_axis_tuser,   // file_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tick[31:0] status[39:32] channel[43:40] first_value[51:44]
  // second_value[59:52] payload_length[87:60] tempo_period[111:88]
  // tempo_valid[112] payload_last[113] truncated[114], zero pad above
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tlast,   // track_done
  output logic [2:0]   m_axis_tuser    // kind
);

  logic              accept;
  logic              have;
  logic              space;
  mtep_pkg::result_t res;
  mtep_pkg::result_t out;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  mtep_core #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .track_end_i  (s_axis_tlast),
    .file_start_i (s_axis_tuser),
    .have_o       (have),
    .res_o        (res)
  );

  mtep_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && have),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out)
  );

  assign m_axis_tdata = {5'b0, out.truncated, out.payload_last, out.tempo_valid,
                         out.tempo_period, out.payload_length, out.second_value,
                         out.first_value, out.channel, out.status, out.tick};
  assign m_axis_tlast = out.track_done;
  assign m_axis_tuser = out.kind;

endmodule
